// File: rtl/sri_pkg.sv
package sri_pkg;

	localparam int unsigned ADDR_W = 128;
	localparam int unsigned NUM_REGS = 8;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [1:0] KIND_IPV4 = 2'd0;
	localparam logic [1:0] KIND_IPV6 = 2'd1;
	localparam logic [1:0] KIND_FC = 2'd2;
	localparam logic [1:0] KIND_DYN = 2'd3;

	localparam logic [15:0] PORT_TOP = 16'hffff;
	localparam logic [7:0] NOT_SUBNET = 8'd255;
	localparam int unsigned IPV4_BYTES = 4;
	localparam int unsigned IPV6_BYTES = 16;
	localparam int unsigned FC_BYTES = 3;

	localparam logic [2:0] REG_KIND = 3'd0;
	localparam logic [2:0] REG_PROTO = 3'd1;
	localparam logic [2:0] REG_PLO = 3'd2;
	localparam logic [2:0] REG_PHI = 3'd3;
	localparam logic [2:0] REG_SU = 3'd4;
	localparam logic [2:0] REG_SL = 3'd5;
	localparam logic [2:0] REG_EU = 3'd6;
	localparam logic [2:0] REG_EL = 3'd7;

	typedef struct packed {
		logic [1:0] peer_kind;
		logic [7:0] peer_protocol;
		logic [15:0] peer_port_low;
		logic [15:0] peer_port_high;
		logic [63:0] peer_start_upper;
		logic [63:0] peer_start_lower;
		logic [63:0] peer_end_upper;
		logic [63:0] peer_end_lower;
	} peer_t;

	typedef struct packed {
		logic overlap_found;
		logic [7:0] result_protocol;
		logic [15:0] result_port_low;
		logic [15:0] result_port_high;
		logic [63:0] result_start_upper;
		logic [63:0] result_start_lower;
		logic [63:0] result_end_upper;
		logic [63:0] result_end_lower;
		logic [7:0] prefix_length;
	} result_t;

	// configured selector
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] protocol;
		logic [15:0] port_low;
		logic [15:0] port_high;
		logic [127:0] start_addr;
		logic [127:0] end_addr;
	} own_t;

	// front-end classification handed to the back end
	typedef struct packed {
		logic match;
		logic fc;
		logic [7:0] len;
		logic [7:0] protocol;
		logic [15:0] port_low;
		logic [15:0] port_high;
		logic [127:0] first_addr;
		logic [127:0] to_addr;
	} job_t;

endpackage

// File: rtl/sri_if.sv
interface sri_peer_if import sri_pkg::*; ();
	logic valid;
	logic ready;
	peer_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface sri_result_if import sri_pkg::*; ();
	logic valid;
	logic ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/sri_front.sv
module sri_front import sri_pkg::*; #(
	parameter int unsigned ADDRESS_BITS = ADDR_W
) (
	input logic clk,
	input logic arst_n,
	input own_t own,
	input logic in_valid,
	output logic in_ready,
	input peer_t in_data,
	output logic job_valid,
	input logic job_ready,
	output job_t job
);

	logic [7:0] len;
	logic [127:0] mask, osa, oea, psa, pea, fa, ta;
	logic own_opq, peer_opq, own_any, peer_any, opaque;
	logic [15:0] plo, phi;
	logic [7:0] proto;
	logic ok;
	job_t nxt;
	logic [7:0] raw_len;

	always_comb begin
		case (own.kind)
			KIND_IPV4: raw_len = 8'(8 * IPV4_BYTES);
			KIND_FC: raw_len = 8'(8 * FC_BYTES);
			default: raw_len = 8'(8 * IPV6_BYTES);
		endcase
		len = (raw_len > 8'(ADDRESS_BITS)) ? 8'(ADDRESS_BITS) : raw_len;
		mask = ~({128{1'b1}} >> len);
		osa = own.start_addr & mask;
		oea = own.end_addr & mask;
		psa = {in_data.peer_start_upper, in_data.peer_start_lower} & mask;
		pea = {in_data.peer_end_upper, in_data.peer_end_lower} & mask;
		fa = (osa > psa) ? osa : psa;
		ta = (oea > pea) ? pea : oea;
		own_opq = own.port_low == PORT_TOP && own.port_high == 16'd0;
		peer_opq = in_data.peer_port_low == PORT_TOP && in_data.peer_port_high == 16'd0;
		own_any = own.port_low == 16'd0 && own.port_high == PORT_TOP;
		peer_any = in_data.peer_port_low == 16'd0 && in_data.peer_port_high == PORT_TOP;
		opaque = (own_opq && peer_opq) || (own_opq && peer_any) || (peer_opq && own_any);
		plo = (own.port_low > in_data.peer_port_low) ? own.port_low : in_data.peer_port_low;
		phi = (own.port_high < in_data.peer_port_high) ? own.port_high
			: in_data.peer_port_high;
		if (opaque) begin
			plo = PORT_TOP;
			phi = 16'd0;
		end
		proto = (own.protocol > in_data.peer_protocol) ? own.protocol : in_data.peer_protocol;
		// opaque ports skip the empty port-range check
		ok = own.kind != KIND_DYN && in_data.peer_kind != KIND_DYN
			&& own.kind == in_data.peer_kind
			&& !(own.protocol != in_data.peer_protocol && own.protocol != 8'd0
				&& in_data.peer_protocol != 8'd0)
			&& (opaque || !(plo > phi)) && !(fa > ta);
		nxt.match = ok;
		nxt.fc = own.kind == KIND_FC;
		nxt.len = len;
		nxt.protocol = proto;
		nxt.port_low = plo;
		nxt.port_high = phi;
		nxt.first_addr = (own.kind == KIND_FC) ? osa : fa;
		nxt.to_addr = (own.kind == KIND_FC) ? oea : ta;
	end

	// single stage register
	logic v_s1;
	assign in_ready = !v_s1 || job_ready;
	assign job_valid = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			job <= nxt;
		end
	end

endmodule

// File: rtl/sri_queue.sv
module sri_queue import sri_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input job_t wr_data,
	output logic rd_valid,
	input logic rd_ready,
	output job_t rd_data
);

	// two-entry queue between front and back end
	job_t mem_q [QUEUE_DEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign wr_ready = cnt_q != 2'(QUEUE_DEPTH);
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

// File: rtl/sri_back.sv
module sri_back import sri_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_ready,
	input job_t job,
	output logic out_valid,
	input logic out_ready,
	output result_t out_data
);

	logic [127:0] diff;
	logic [7:0] p;
	logic [127:0] tail;
	logic [7:0] pre;
	result_t nxt;

	// prefix: leading common bits, then start must be all zero and end all ones below it
	always_comb begin
		diff = job.first_addr ^ job.to_addr;
		p = 8'd128;
		for (int i = 0; i < 128; i++) begin
			if (diff[i]) p = 8'(127 - i);
		end
		tail = ({128{1'b1}} >> (p + 8'd1)) & ~({128{1'b1}} >> job.len);
		if (p >= job.len) begin
			pre = job.len;
		end else begin
			if ((job.first_addr & tail) != 128'd0 || (job.to_addr & tail) != tail) begin
				pre = NOT_SUBNET;
			end else begin
				pre = p;
			end
		end
		nxt = '0;
		if (job.match) begin
			nxt.overlap_found = 1'b1;
			nxt.result_protocol = job.protocol;
			nxt.result_port_low = job.port_low;
			nxt.result_port_high = job.port_high;
			{nxt.result_start_upper, nxt.result_start_lower} = job.first_addr;
			{nxt.result_end_upper, nxt.result_end_lower} = job.to_addr;
			nxt.prefix_length = pre;
		end
	end

	// output register
	assign job_ready = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (job_ready) begin
			out_valid <= job_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready && job_valid) begin
			out_data <= nxt;
		end
	end

endmodule

// File: rtl/selector_range_intersection.sv
// channel  | dir | payload
// peer     | in  | peer_t: kind, protocol, port range, address range
// result   | out | result_t: overlap flag, protocol, ports, addresses, prefix
// cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
// One transaction per cycle sustained while result is ready. An accepted
// transaction passes the front register, the two-entry queue and the back
// output register before it shows on result. Each stage stalls only on its
// own downstream ready. Reset clears valids and loads register defaults.
module selector_range_intersection import sri_pkg::*; #(
	parameter int unsigned ADDRESS_BITS = ADDR_W
) (
	input logic clk,
	input logic arst_n,
	sri_peer_if.sink peer,
	sri_result_if.source result,
	input logic cfg_we,
	input logic [REG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	own_t own_q;
	logic fv, fr, qv, qr;
	job_t fj, qj;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q.kind <= KIND_DYN;
			own_q.protocol <= 8'd0;
			own_q.port_low <= 16'd0;
			own_q.port_high <= PORT_TOP;
			own_q.start_addr <= '0;
			own_q.end_addr <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KIND: own_q.kind <= cfg_data[1:0];
				REG_PROTO: own_q.protocol <= cfg_data[7:0];
				REG_PLO: own_q.port_low <= cfg_data[15:0];
				REG_PHI: own_q.port_high <= cfg_data[15:0];
				REG_SU: own_q.start_addr[127:64] <= cfg_data;
				REG_SL: own_q.start_addr[63:0] <= cfg_data;
				REG_EU: own_q.end_addr[127:64] <= cfg_data;
				REG_EL: own_q.end_addr[63:0] <= cfg_data;
				default: ;
			endcase
		end
	end

	sri_front #(.ADDRESS_BITS(ADDRESS_BITS)) u_front (
		.clk, .arst_n, .own(own_q),
		.in_valid(peer.valid), .in_ready(peer.ready), .in_data(peer.data),
		.job_valid(fv), .job_ready(fr), .job(fj)
	);

	sri_queue u_queue (
		.clk, .arst_n,
		.wr_valid(fv), .wr_ready(fr), .wr_data(fj),
		.rd_valid(qv), .rd_ready(qr), .rd_data(qj)
	);

	sri_back u_back (
		.clk, .arst_n,
		.job_valid(qv), .job_ready(qr), .job(qj),
		.out_valid(result.valid), .out_ready(result.ready), .out_data(result.data)
	);

	// no-match results carry zero payload; this checks the prefix length
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.data.overlap_found |-> result.data.prefix_length == 8'd0)
		else $error("non-match with prefix");
	// dynamic own kind never yields a match from a fresh front entry
	a_dyn: assert property (@(posedge clk) disable iff (!arst_n)
		peer.valid && peer.ready && own_q.kind == KIND_DYN |=> !fj.match)
		else $error("dynamic matched");
	// prefix either a valid count or not-subnet
	a_pre: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.data.prefix_length <= 8'd128
			|| result.data.prefix_length == NOT_SUBNET)
		else $error("bad prefix");

endmodule

// File: verif/sri_tb_if.sv
// Channel interfaces are taken from the RTL (sri_peer_if, sri_result_if).
// This file only holds the selector types shared by the bench.
package sri_tb_pkg;
	import sri_pkg::*;

	// the configured selector as the bench tracks it
	typedef struct {
		logic [1:0] kind;
		logic [7:0] protocol;
		logic [15:0] port_low;
		logic [15:0] port_high;
		logic [127:0] start_addr;
		logic [127:0] end_addr;
	} own_sel_t;

	// one directed row: a peer selector and, where it is obvious,
	// the result that it must give
	typedef struct {
		peer_t peer;
		logic typed;
		result_t want;
	} stim_row_t;
endpackage

// File: verif/selector_range_intersection_tb.sv
module selector_range_intersection_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sri_pkg::*;
	import sri_tb_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	sri_peer_if peer ();
	sri_result_if result ();

	selector_range_intersection dut (
		.clk(clk), .arst_n(arst_n), .peer(peer.sink), .result(result.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	own_sel_t own;
	result_t intersections_due[$];
	int unsigned mismatches = 0;
	int unsigned checked = 0;
	int unsigned matches_seen = 0;
	int unsigned configs_used = 0;
	bit stim_done = 1'b0;

	initial begin
		peer.valid = 1'b0;
		peer.data = '0;
		result.ready = 1'b0;
	end

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// gap length: mostly short, sometimes long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [127:0] len_mask(int unsigned n);
		logic [127:0] m;
		m = '0;
		for (int i = 0; i < 128; i++) begin
			if (i < n) m[127 - i] = 1'b1;
		end
		return m;
	endfunction

	// common prefix of a range, or NOT_SUBNET when the range is no subnet
	function automatic logic [7:0] subnet_prefix(logic [127:0] lo, logic [127:0] hi,
			int unsigned n);
		int unsigned p;
		logic [127:0] tail;
		p = 0;
		while (p < n && lo[127 - p] == hi[127 - p]) p++;
		if (p >= n) return 8'(n);
		tail = len_mask(n) & ~len_mask(p + 1);
		if ((lo & tail) != '0) return NOT_SUBNET;
		if ((hi & tail) != tail) return NOT_SUBNET;
		return 8'(p);
	endfunction

	// expected intersection of a peer selector with the configured one
	function automatic result_t predict_result(peer_t p, own_sel_t o);
		result_t r;
		logic [127:0] m, os, oe, ps, pe, lo_a, hi_a;
		logic [15:0] plo, phi;
		bit own_opq, peer_opq, own_any, peer_any;
		int unsigned n;
		r = '0;
		if (o.kind == KIND_DYN || p.peer_kind == KIND_DYN || o.kind != p.peer_kind)
			return r;
		if (o.protocol != p.peer_protocol && o.protocol != 0 && p.peer_protocol != 0)
			return r;
		own_opq = o.port_low == PORT_TOP && o.port_high == 0;
		peer_opq = p.peer_port_low == PORT_TOP && p.peer_port_high == 0;
		own_any = o.port_low == 0 && o.port_high == PORT_TOP;
		peer_any = p.peer_port_low == 0 && p.peer_port_high == PORT_TOP;
		if ((own_opq && peer_opq) || (own_opq && peer_any) || (peer_opq && own_any)) begin
			plo = PORT_TOP;
			phi = '0;
		end else begin
			plo = o.port_low > p.peer_port_low ? o.port_low : p.peer_port_low;
			phi = o.port_high < p.peer_port_high ? o.port_high : p.peer_port_high;
			if (plo > phi) return r;
		end
		n = 8 * (o.kind == KIND_IPV4 ? IPV4_BYTES : (o.kind == KIND_FC ? FC_BYTES : IPV6_BYTES));
		m = len_mask(n);
		os = o.start_addr & m;
		oe = o.end_addr & m;
		ps = {p.peer_start_upper, p.peer_start_lower} & m;
		pe = {p.peer_end_upper, p.peer_end_lower} & m;
		lo_a = os > ps ? os : ps;
		hi_a = oe > pe ? pe : oe;
		if (lo_a > hi_a) return r;
		if (o.kind == KIND_FC) begin
			lo_a = os;
			hi_a = oe;
		end
		r.overlap_found = 1'b1;
		r.result_protocol = o.protocol > p.peer_protocol ? o.protocol : p.peer_protocol;
		r.result_port_low = plo;
		r.result_port_high = phi;
		{r.result_start_upper, r.result_start_lower} = lo_a;
		{r.result_end_upper, r.result_end_lower} = hi_a;
		r.prefix_length = subnet_prefix(lo_a, hi_a, n);
		return r;
	endfunction

	// register write, tracked in the bench's own copy
	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_KIND: own.kind = val[1:0];
			REG_PROTO: own.protocol = val[7:0];
			REG_PLO: own.port_low = val[15:0];
			REG_PHI: own.port_high = val[15:0];
			REG_SU: own.start_addr[127:64] = val;
			REG_SL: own.start_addr[63:0] = val;
			REG_EU: own.end_addr[127:64] = val;
			REG_EL: own.end_addr[63:0] = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_selector(logic [1:0] k, logic [7:0] pr, logic [15:0] pl,
			logic [15:0] ph, logic [127:0] sa, logic [127:0] ea);
		write_reg(REG_KIND, 64'(k));
		write_reg(REG_PROTO, 64'(pr));
		write_reg(REG_PLO, 64'(pl));
		write_reg(REG_PHI, 64'(ph));
		write_reg(REG_SU, sa[127:64]);
		write_reg(REG_SL, sa[63:0]);
		write_reg(REG_EU, ea[127:64]);
		write_reg(REG_EL, ea[63:0]);
		configs_used++;
	endtask

	// push one peer selector, record its expected result at acceptance;
	// valid stays high into the next transaction when there is no gap
	task automatic send_peer(peer_t p, bit typed, result_t want);
		int unsigned g;
		g = pick_gap();
		if (g != 0) begin
			peer.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		peer.valid <= 1'b1;
		peer.data <= p;
		do @(posedge clk); while (!peer.ready);
		intersections_due.push_back(typed ? want : predict_result(p, own));
	endtask

	// wait until every result is back, plus pipeline drain
	task automatic drain();
		peer.valid <= 1'b0;
		while (intersections_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [127:0] rand_addr();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	// address near a base so ranges overlap often
	function automatic logic [127:0] near(logic [127:0] base, int unsigned n);
		logic [127:0] d;
		d = {$urandom, $urandom, $urandom, $urandom} >> $urandom_range(0, 127);
		d = d & (len_mask(n) >> 0);
		return ($urandom_range(0, 1) ? base + d : base - d);
	endfunction

	function automatic int unsigned kind_len(logic [1:0] k);
		return k == KIND_IPV4 ? 32 : (k == KIND_FC ? 24 : 128);
	endfunction

	function automatic peer_t rand_peer();
		peer_t p;
		int unsigned r, n;
		logic [127:0] a, b;
		p.peer_kind = ($urandom_range(0, 9) < 8) ? own.kind : 2'($urandom_range(0, 3));
		r = $urandom_range(0, 9);
		p.peer_protocol = r < 4 ? own.protocol : (r < 7 ? 8'd0 : 8'($urandom));
		r = $urandom_range(0, 9);
		if (r == 0) begin
			p.peer_port_low = PORT_TOP;
			p.peer_port_high = 16'd0;
		end else if (r == 1) begin
			p.peer_port_low = 16'd0;
			p.peer_port_high = PORT_TOP;
		end else begin
			p.peer_port_low = 16'($urandom);
			p.peer_port_high = 16'($urandom);
			if (r < 8 && p.peer_port_low > p.peer_port_high)
				{p.peer_port_low, p.peer_port_high} = {p.peer_port_high, p.peer_port_low};
		end
		n = kind_len(own.kind);
		r = $urandom_range(0, 9);
		if (r < 3) begin
			// subnet shaped range
			a = rand_addr() & len_mask($urandom_range(0, n));
			b = a | ~len_mask($urandom_range(0, n));
		end else if (r < 8) begin
			a = near(own.start_addr, n);
			b = near(own.end_addr, n);
		end else begin
			a = rand_addr();
			b = rand_addr();
		end
		{p.peer_start_upper, p.peer_start_lower} = a;
		{p.peer_end_upper, p.peer_end_lower} = b;
		return p;
	endfunction

	function automatic peer_t mk_peer(logic [1:0] k, logic [7:0] pr, logic [15:0] pl,
			logic [15:0] ph, logic [127:0] sa, logic [127:0] ea);
		peer_t p;
		p.peer_kind = k;
		p.peer_protocol = pr;
		p.peer_port_low = pl;
		p.peer_port_high = ph;
		{p.peer_start_upper, p.peer_start_lower} = sa;
		{p.peer_end_upper, p.peer_end_lower} = ea;
		return p;
	endfunction

	// result side: random stalls, compare with oldest expectation
	initial begin
		result_t want;
		result_t got;
		int unsigned g;
		@(posedge arst_n);
		forever begin
			g = pick_gap();
			if (g != 0) begin
				result.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			result.ready <= 1'b1;
			@(posedge clk);
			if (result.valid) begin
				got = result.data;
				if (intersections_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transaction %p", got);
				end else begin
					want = intersections_due.pop_front();
					checked++;
					if (got.overlap_found) matches_seen++;
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch #%0d\n  exp %p\n  got %p", checked, want, got);
					end
				end
			end
		end
	end

	// stimulus
	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		peer_t p;
		logic [127:0] ones;
		ones = '1;
		own.kind = KIND_DYN;
		own.protocol = '0;
		own.port_low = '0;
		own.port_high = PORT_TOP;
		own.start_addr = '0;
		own.end_addr = '1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// after reset the configured kind is dynamic: nothing matches
		for (int k = 0; k < 4; k++) begin
			row.peer = mk_peer(2'(k), 8'd6, 16'd0, PORT_TOP, '0, ones);
			row.typed = 1'b1;
			row.want = '0;
			rows.push_back(row);
		end
		foreach (rows[i]) send_peer(rows[i].peer, rows[i].typed, rows[i].want);
		drain();
		rows.delete();

		// IPv4, any protocol, full ports, whole space
		load_selector(KIND_IPV4, 8'd0, 16'd0, PORT_TOP, '0, ones);
		row.typed = 1'b0;
		row.want = '0;
		row.peer = mk_peer(KIND_IPV4, 8'd255, 16'd0, PORT_TOP, '0, ones); rows.push_back(row);
		row.peer = mk_peer(KIND_IPV4, 8'd17, PORT_TOP, 16'd0, '0, ones); rows.push_back(row);
		row.peer = mk_peer(KIND_IPV4, 8'd0, 16'd80, 16'd80,
			{32'h0a000000, 96'h0}, {32'h0a0000ff, 96'h0}); rows.push_back(row);
		row.peer = mk_peer(KIND_IPV4, 8'd0, 16'd10, 16'd5, '0, ones); rows.push_back(row);
		row.peer = mk_peer(KIND_IPV4, 8'd1, 16'd0, PORT_TOP,
			{32'h0a000005, 96'h0}, {32'h0a000003, 96'h0}); rows.push_back(row);
		row.peer = mk_peer(KIND_IPV6, 8'd1, 16'd0, PORT_TOP, '0, ones);
		row.typed = 1'b1; rows.push_back(row);
		row.typed = 1'b0;
		row.peer = mk_peer(KIND_IPV4, 8'd0, 16'd0, 16'd0,
			{32'h01020304, 96'h0}, {32'h01020304, 96'h0}); rows.push_back(row);
		foreach (rows[i]) send_peer(rows[i].peer, rows[i].typed, rows[i].want);
		drain();
		rows.delete();

		// IPv6, opaque own ports, protocol set
		load_selector(KIND_IPV6, 8'd6, PORT_TOP, 16'd0,
			{16'h2001, 112'h0}, {16'h2001, 112'hffff_ffff_ffff_ffff_ffff_ffff_ffff});
		row.typed = 1'b0;
		row.peer = mk_peer(KIND_IPV6, 8'd6, 16'd0, PORT_TOP, '0, ones); rows.push_back(row);
		row.peer = mk_peer(KIND_IPV6, 8'd0, PORT_TOP, 16'd0, '0, ones); rows.push_back(row);
		row.peer = mk_peer(KIND_IPV6, 8'd6, 16'd1, 16'd2, '0, ones); rows.push_back(row);
		row.peer = mk_peer(KIND_IPV6, 8'd17, 16'd0, PORT_TOP, '0, ones);
		row.typed = 1'b1; row.want = '0; rows.push_back(row);
		row.typed = 1'b0;
		row.peer = mk_peer(KIND_IPV6, 8'd0, 16'd0, PORT_TOP, ones, ones); rows.push_back(row);
		foreach (rows[i]) send_peer(rows[i].peer, rows[i].typed, rows[i].want);
		drain();
		rows.delete();

		// Fibre Channel: the configured range comes back
		load_selector(KIND_FC, 8'd255, 16'd0, PORT_TOP,
			{24'h010200, 104'h0}, {24'h0102ff, 104'h0});
		row.typed = 1'b0;
		row.peer = mk_peer(KIND_FC, 8'd0, PORT_TOP, 16'd0, '0, ones); rows.push_back(row);
		row.peer = mk_peer(KIND_FC, 8'd255, 16'd7, 16'd9,
			{24'h010280, 104'h0}, {24'h010290, 104'h0}); rows.push_back(row);
		row.peer = mk_peer(KIND_FC, 8'd0, 16'd0, PORT_TOP,
			{24'h020000, 104'h0}, ones); rows.push_back(row);
		row.peer = mk_peer(KIND_DYN, 8'd0, 16'd0, PORT_TOP, '0, ones);
		row.typed = 1'b1; row.want = '0; rows.push_back(row);
		foreach (rows[i]) send_peer(rows[i].peer, rows[i].typed, rows[i].want);
		drain();
		rows.delete();

		// random phases over random configurations, extremes among them
		for (int ph = 0; ph < 13; ph++) begin
			logic [127:0] s, e;
			logic [15:0] pl, phh;
			int unsigned n;
			logic [1:0] k;
			k = ph < 3 ? 2'(ph) : 2'($urandom_range(0, 3));
			n = kind_len(k);
			s = rand_addr() & len_mask($urandom_range(0, n));
			e = ($urandom_range(0, 1)) ? (s | ~len_mask($urandom_range(0, n))) : rand_addr();
			if (ph == 3) begin
				s = '0;
				e = ones;
			end
			pl = 16'($urandom);
			phh = 16'($urandom);
			if (pl > phh) {pl, phh} = {phh, pl};
			case (ph % 4)
				0: begin pl = 16'd0; phh = PORT_TOP; end
				1: begin pl = PORT_TOP; phh = 16'd0; end
				default: ;
			endcase
			load_selector(k, ph == 4 ? 8'd255 : 8'($urandom_range(0, 3) == 0 ? 0 : $urandom),
				pl, phh, s, e);
			for (int i = 0; i < 150; i++) begin
				p = rand_peer();
				send_peer(p, 1'b0, '0);
			end
			drain();
		end
		stim_done = 1'b1;
	end

	// end of run
	initial begin
		wait (stim_done);
		$display("Checked %0d intersections (%0d with overlap) over %0d selector settings.",
			checked, matches_seen, configs_used);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Regression FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("timeout with %0d results outstanding", intersections_due.size());
		$display("Regression FAIL");
		$finish;
	end
endmodule

// File: selector_range_intersection.f
rtl/sri_pkg.sv
rtl/sri_if.sv
rtl/sri_front.sv
rtl/sri_queue.sv
rtl/sri_back.sv
rtl/selector_range_intersection.sv
verif/sri_tb_if.sv
verif/selector_range_intersection_tb.sv
